// ===== sv/sorted_key_set_insert_remove_defines.svh =====
// Assertion macros for the sorted key set block.
// Included by sorted_key_set_insert_remove.sv, which carries the concurrent assertions; expects clk_i and rst_ni.
`ifndef SORTED_KEY_SET_INSERT_REMOVE_DEFINES_SVH
`define SORTED_KEY_SET_INSERT_REMOVE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SKS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// An antecedent that forces a consequent on the following clock edge.
`define SKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// An antecedent that forces a consequent on the same clock edge.
`define SKS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/sks_pkg.sv =====
// Package for the sorted key set block: operation codes, sequencer states and field widths.
// Has no dependencies; imported by sorted_key_set_insert_remove, its checker and the test.
package sks_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned OpcodeW    = 2;
  localparam int unsigned InKeyW     = 32;
  localparam int unsigned IndexW     = 8;
  localparam int unsigned CountOutW  = 9;
  localparam int unsigned ReadKeyW   = 32;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned OutDataW   = 48;

  // Operation codes carried on the input tuser.
  typedef enum logic [OpcodeW-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_SHIFT,
    ST_FINAL,
    ST_READ,
    ST_RDATA,
    ST_FINISH
  } state_e;

endpackage

// ===== sv/sorted_key_set_insert_remove.sv =====
// Top level of the sorted key set: table memory, search and shift sequencer, result register.
// Depends on sks_pkg and sorted_key_set_insert_remove_defines.svh.
//
// Keeps a strictly ascending, duplicate-free table of keys in a single-port-write, registered-read
// memory. Each input transfer (opcode on tuser) adds a key, removes a key or reads the entry at an
// index, and produces exactly one output transfer. An add or remove first runs a binary search
// through one shared comparator, each probe passing through ST_SEARCH and ST_CMP, then moves
// every entry above the insert or delete point by one place, one entry per cycle through the
// memory port, and a change is committed in ST_FINAL. A read in range passes through ST_READ,
// ST_RDATA and ST_FINISH. The input is ready only while the sequencer is idle; a finished
// result waits in the output register, so a new transfer is taken while the previous result is
// still unclaimed. The memory needs no clearing after reset.
`include "sorted_key_set_insert_remove_defines.svh"

module sorted_key_set_insert_remove #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: key [31:0], index [39:32]
  input  logic [sks_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: opcode [1:0]
  input  logic [sks_pkg::OpcodeW-1:0]    s_axis_tuser,
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: changed [0], table_full [1], entry_count [10:2], read_key [42:11],
  // read_valid [43], zero fill [47:44]
  output logic [sks_pkg::OutDataW-1:0]   m_axis_tdata
);

  import sks_pkg::*;

  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CMPW = (CW > IndexW) ? CW : IndexW;

  // Table memory
  logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [KEY_WIDTH-1:0] rdata_q;

  // Sequencer state
  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        lo_q, lo_d;
  logic [CW-1:0]        hi_q, hi_d;
  logic [CW-1:0]        mid_q, mid_d;
  logic                 found_q, found_d;
  logic [AW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]        rd_left_q, rd_left_d;
  logic [AW-1:0]        wr_addr_q, wr_addr_d;
  logic                 wr_pend_q, wr_pend_d;

  // Latched item and result fields
  op_e                  op_q, op_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [IndexW-1:0]    idx_q, idx_d;
  logic                 changed_q, changed_d;
  logic                 full_q, full_d;
  logic [KEY_WIDTH-1:0] rkey_q, rkey_d;
  logic                 rvalid_q, rvalid_d;

  // Output register
  logic                 m_valid_q, m_valid_d;
  logic [OutDataW-1:0]  m_data_q, m_data_d;

  logic                 in_fire;
  logic [63:0]          in_key64;
  logic [63:0]          rkey64;
  logic [31:0]          count32;
  logic [CMPW-1:0]      idx_ext;
  logic [CMPW-1:0]      cnt_ext;
  logic                 key_less;
  logic                 key_equal;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_key64      = {32'd0, s_axis_tdata[InKeyW-1:0]};
  assign idx_ext       = CMPW'(idx_q);
  assign cnt_ext       = CMPW'(count_q);
  assign rkey64        = 64'(rkey_q);
  assign count32       = 32'(count_q);

  // Shared comparator of the search
  assign key_less  = rdata_q < key_q;
  assign key_equal = rdata_q == key_q;

  // Next state and datapath control
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    found_d   = found_q;
    rd_ptr_d  = rd_ptr_q;
    rd_left_d = rd_left_q;
    wr_addr_d = wr_addr_q;
    wr_pend_d = wr_pend_q;
    op_d      = op_q;
    key_d     = key_q;
    idx_d     = idx_q;
    changed_d = changed_q;
    full_d    = full_q;
    rkey_d    = rkey_q;
    rvalid_d  = rvalid_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = rdata_q;
    mem_raddr = '0;

    // The consumer takes the waiting result.
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d      = op_e'(s_axis_tuser);
          key_d     = in_key64[KEY_WIDTH-1:0];
          idx_d     = s_axis_tdata[InKeyW +: IndexW];
          changed_d = 1'b0;
          full_d    = 1'b0;
          rkey_d    = '0;
          rvalid_d  = 1'b0;
          lo_d      = '0;
          hi_d      = count_q;
          found_d   = 1'b0;
          unique case (op_e'(s_axis_tuser))
            OP_ADD, OP_REMOVE: state_d = ST_SEARCH;
            OP_READ:           state_d = ST_READ;
            default:           state_d = ST_FINISH;
          endcase
        end
      end

      ST_SEARCH: begin
        if (lo_q < hi_q) begin
          // Probe the middle of the remaining range.
          mid_d     = lo_q + ((hi_q - lo_q) >> 1);
          mem_raddr = mid_d[AW-1:0];
          state_d   = ST_CMP;
        end else if (op_q == OP_ADD) begin
          // Insert point found at lo.
          if (found_q) begin
            state_d = ST_FINISH;
          end else if (count_q == CW'(TABLE_DEPTH)) begin
            full_d  = 1'b1;
            state_d = ST_FINISH;
          end else if (count_q == lo_q) begin
            state_d = ST_FINAL;
          end else begin
            rd_ptr_d  = AW'(count_q - 1'b1);
            rd_left_d = count_q - lo_q;
            wr_pend_d = 1'b0;
            state_d   = ST_SHIFT;
          end
        end else begin
          // Remove: the key sits at lo when found.
          if (!found_q) begin
            state_d = ST_FINISH;
          end else if (count_q - 1'b1 == lo_q) begin
            state_d = ST_FINAL;
          end else begin
            rd_ptr_d  = AW'(lo_q + 1'b1);
            rd_left_d = count_q - lo_q - 1'b1;
            wr_pend_d = 1'b0;
            state_d   = ST_SHIFT;
          end
        end
      end

      ST_CMP: begin
        if (key_less) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        if (key_equal) begin
          found_d = 1'b1;
        end
        state_d = ST_SEARCH;
      end

      ST_SHIFT: begin
        // Write back the entry read in the previous cycle.
        if (wr_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_q;
          mem_wdata = rdata_q;
        end
        if (rd_left_q != '0) begin
          mem_raddr = rd_ptr_q;
          wr_pend_d = 1'b1;
          rd_left_d = rd_left_q - 1'b1;
          if (op_q == OP_ADD) begin
            wr_addr_d = rd_ptr_q + 1'b1;
            rd_ptr_d  = rd_ptr_q - 1'b1;
          end else begin
            wr_addr_d = rd_ptr_q - 1'b1;
            rd_ptr_d  = rd_ptr_q + 1'b1;
          end
        end else begin
          wr_pend_d = 1'b0;
          state_d   = ST_FINAL;
        end
      end

      ST_FINAL: begin
        changed_d = 1'b1;
        if (op_q == OP_ADD) begin
          mem_we    = 1'b1;
          mem_waddr = lo_q[AW-1:0];
          mem_wdata = key_q;
          count_d   = count_q + 1'b1;
        end else begin
          count_d   = count_q - 1'b1;
        end
        state_d = ST_FINISH;
      end

      ST_READ: begin
        if (idx_ext < cnt_ext) begin
          mem_raddr = idx_ext[AW-1:0];
          state_d   = ST_RDATA;
        end else begin
          state_d   = ST_FINISH;
        end
      end

      ST_RDATA: begin
        rkey_d   = rdata_q;
        rvalid_d = 1'b1;
        state_d  = ST_FINISH;
      end

      ST_FINISH: begin
        // Load the result once the output register is free.
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {4'd0, rvalid_q, rkey64[ReadKeyW-1:0], count32[CountOutW-1:0],
                       full_q, changed_q};
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  // Payload and search registers
  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    found_q   <= found_d;
    rd_ptr_q  <= rd_ptr_d;
    rd_left_q <= rd_left_d;
    wr_addr_q <= wr_addr_d;
    op_q      <= op_d;
    key_q     <= key_d;
    idx_q     <= idx_d;
    changed_q <= changed_d;
    full_q    <= full_d;
    rkey_q    <= rkey_d;
    rvalid_q  <= rvalid_d;
    m_data_q  <= m_data_d;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Assertions
  `SKS_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(TABLE_DEPTH), "key count exceeds table depth")
  `SKS_ASSERT_NEXT(a_count_only_final, state_q != ST_FINAL, $stable(count_q), "count moved outside final step")
  `SKS_ASSERT_SAME(a_write_window, mem_we, (state_q == ST_SHIFT) || (state_q == ST_FINAL), "table written outside shift or final step")
  `SKS_ASSERT_SAME(a_result_source, $rose(m_axis_tvalid), $past(state_q) == ST_FINISH, "result appeared without a finish step")
  `SKS_ASSERT_SAME(a_count_step, count_q != $past(count_q), (count_q == $past(count_q) + 1'b1) || (count_q + 1'b1 == $past(count_q)), "count changed by more than one")

endmodule

// ===== sim/sorted_key_set_insert_remove_checker.sv =====
// Checker for the sorted key set: watches both stream channels, predicts every result and
// compares it field by field. Depends on sks_pkg; instantiated by sorted_key_set_insert_remove_test.
module sorted_key_set_insert_remove_checker #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  // tdata: key [31:0], index [39:32]
  input  logic [sks_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: opcode [1:0]
  input  logic [sks_pkg::OpcodeW-1:0]  s_axis_tuser,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: changed [0], table_full [1], entry_count [10:2], read_key [42:11],
  // read_valid [43], zero fill [47:44]
  input  logic [sks_pkg::OutDataW-1:0] m_axis_tdata,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import sks_pkg::*;

  typedef struct packed {
    logic        changed;
    logic        table_full;
    logic [8:0]  entry_count;
    logic [31:0] read_key;
    logic        read_valid;
  } outcome_t;

  // Own copy of the table: keys ascending, only the first keys_held entries are meaningful.
  logic [31:0] key_table [TABLE_DEPTH];
  int unsigned keys_held;
  outcome_t    results_due [$];
  int unsigned mismatches;

  // Applies one request to the table copy and returns the result it must produce.
  function automatic outcome_t update_key_table(op_e op, logic [31:0] key, logic [7:0] idx);
    outcome_t    res;
    int unsigned pos;
    int unsigned j;
    bit          present;
    res = '0;
    pos = 0;
    while (pos < keys_held && key_table[pos] < key) pos++;
    present = (pos < keys_held) && (key_table[pos] == key);
    case (op)
      OP_ADD: begin
        if (!present) begin
          if (keys_held >= TABLE_DEPTH) begin
            res.table_full = 1'b1;
          end else begin
            for (j = keys_held; j > pos; j--) key_table[j] = key_table[j-1];
            key_table[pos] = key;
            keys_held++;
            res.changed = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (present) begin
          for (j = pos; j + 1 < keys_held; j++) key_table[j] = key_table[j+1];
          keys_held--;
          res.changed = 1'b1;
        end
      end
      OP_READ: begin
        if (idx < keys_held) begin
          res.read_key   = key_table[idx];
          res.read_valid = 1'b1;
        end
      end
      default: ;
    endcase
    res.entry_count = 9'(keys_held);
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Requests are predicted as they are taken; results are compared against the oldest one due.
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t due;
    outcome_t fresh;
    if (!rst_ni) begin
      keys_held = 0;
      results_due.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        fresh = update_key_table(op_e'(s_axis_tuser), s_axis_tdata[31:0],
                                 s_axis_tdata[39:32]);
        results_due = {results_due, fresh};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          $error("result transfer with no request outstanding: tdata 0x%0h", m_axis_tdata);
          mismatches++;
        end else begin
          due = results_due.pop_front();
          check_field("changed", 32'(due.changed), 32'(m_axis_tdata[0]));
          check_field("table_full", 32'(due.table_full), 32'(m_axis_tdata[1]));
          check_field("entry_count", 32'(due.entry_count), 32'(m_axis_tdata[10:2]));
          check_field("read_key", due.read_key, m_axis_tdata[42:11]);
          check_field("read_valid", 32'(due.read_valid), 32'(m_axis_tdata[43]));
          check_field("zero fill", 32'd0, 32'(m_axis_tdata[47:44]));
        end
      end
    end
    pending_o    <= results_due.size();
    fail_count_o <= mismatches;
  end

endmodule

// ===== sim/sorted_key_set_insert_remove_test.sv =====
// Top of the sorted key set testbench: clock, reset, request stimulus, result back-pressure
// and the verdict. Depends on sks_pkg, sorted_key_set_insert_remove and its checker.
module sorted_key_set_insert_remove_test;
  import sks_pkg::*;

  localparam int unsigned RunLimit = 36_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata = '0;
  logic [OpcodeW-1:0]    s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  int unsigned           fail_count;
  int unsigned           pending;
  int                    send_calm = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sorted_key_set_insert_remove u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sorted_key_set_insert_remove_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one request and returns at the edge where it is taken; tvalid stays high.
  task automatic send(input op_e op, input logic [31:0] key, input logic [7:0] idx);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = gap_len();
      if ($urandom_range(0, 99) < 2) send_calm = $urandom_range(30, 150);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {idx, key};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering and waits until every predicted result has been transferred.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Result back-pressure: random stalls with occasional calm stretches.
  initial begin : result_sink
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 99) < 2) begin
        calm_left = $urandom_range(50, 200);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (calm_left == 0) stall_left = gap_len();
      end
    end
  end

  initial begin : watchdog
    #RunLimit;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] fill_keys [260];
    logic [31:0] added_keys [$];
    logic [31:0] k;
    int          r;
    int          i;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extreme keys, duplicates, absent removes, reads past the count.
    send(OP_READ,   32'h0000_0000, 8'd0);
    send(OP_REMOVE, 32'h0000_0005, 8'd0);
    send(OP_NOP,    32'hFFFF_FFFF, 8'hFF);
    send(OP_ADD,    32'hFFFF_FFFF, 8'hFF);
    send(OP_ADD,    32'h0000_0000, 8'd0);
    send(OP_ADD,    32'h0000_0000, 8'h55);
    send(OP_ADD,    32'h8000_0000, 8'd0);
    send(OP_ADD,    32'h7FFF_FFFF, 8'd0);
    send(OP_READ,   32'h0000_0000, 8'd0);
    send(OP_READ,   32'hFFFF_FFFF, 8'd3);
    send(OP_READ,   32'h0000_0000, 8'd4);
    send(OP_READ,   32'hFFFF_FFFF, 8'hFF);
    send(OP_REMOVE, 32'h1234_5678, 8'hAA);
    send(OP_REMOVE, 32'h0000_0000, 8'd0);
    send(OP_REMOVE, 32'hFFFF_FFFF, 8'd0);
    send(OP_READ,   32'h0000_0000, 8'd0);
    send(OP_ADD,    32'h0000_0001, 8'd0);
    send(OP_REMOVE, 32'h8000_0000, 8'd0);
    send(OP_NOP,    32'h0000_0000, 8'd0);
    send(OP_REMOVE, 32'h0000_0001, 8'd0);
    send(OP_REMOVE, 32'h7FFF_FFFF, 8'd0);
    send(OP_REMOVE, 32'h7FFF_FFFF, 8'd0);
    send(OP_READ,   32'h0000_0000, 8'd0);
    wait_drained();

    // Small key space, so adds often hit present keys and removes often hit.
    for (i = 0; i < 500; i++) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 47);
      if (r < 40) begin
        send(OP_ADD, k, 8'($urandom_range(0, 255)));
      end else if (r < 70) begin
        send(OP_REMOVE, k, 8'($urandom_range(0, 255)));
      end else if (r < 95) begin
        send(OP_READ, $urandom, ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 50))
                                                             : 8'($urandom_range(0, 255)));
      end else begin
        send(OP_NOP, $urandom, 8'($urandom_range(0, 255)));
      end
    end
    wait_drained();

    // Fill with ascending keys above the small ones until the table is full and adds bounce.
    for (i = 0; i < 260; i++) begin
      fill_keys[i] = 32'h4000_0000 + 32'(i) * 32'h0010_0000 + 32'($urandom_range(0, 32'hF_FFFF));
      send(OP_ADD, fill_keys[i], 8'($urandom_range(0, 255)));
    end
    send(OP_READ, 32'h0, 8'd255);
    send(OP_READ, 32'h0, 8'd0);
    for (i = 0; i < 60; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send(OP_READ, $urandom, 8'($urandom_range(0, 255)));
      end else if (r < 55) begin
        send(OP_ADD, $urandom, 8'($urandom_range(0, 255)));
      end else if (r < 75) begin
        send(OP_ADD, fill_keys[$urandom_range(0, 199)], 8'($urandom_range(0, 255)));
      end else if (r < 90) begin
        send(OP_REMOVE, 32'h3000_0000 + 32'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
      end else begin
        send(OP_NOP, $urandom, 8'($urandom_range(0, 255)));
      end
    end

    // Drain from the top down, with reads in between.
    for (i = 259; i >= 0; i--) begin
      if ($urandom_range(0, 99) < 20) send(OP_READ, $urandom, 8'($urandom_range(0, 255)));
      send(OP_REMOVE, fill_keys[i], 8'($urandom_range(0, 255)));
    end

    // Full-width random keys; removes mostly aim at keys added earlier in this stretch.
    for (i = 0; i < 430; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        k = $urandom;
        added_keys = {added_keys, k};
        send(OP_ADD, k, 8'($urandom_range(0, 255)));
      end else if (r < 65) begin
        if (added_keys.size() > 0 && $urandom_range(0, 99) < 70) begin
          k = added_keys[$urandom_range(0, added_keys.size() - 1)];
        end else begin
          k = $urandom;
        end
        send(OP_REMOVE, k, 8'($urandom_range(0, 255)));
      end else if (r < 95) begin
        send(OP_READ, $urandom, ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 127))
                                                             : 8'($urandom_range(0, 255)));
      end else begin
        send(OP_NOP, $urandom, 8'($urandom_range(0, 255)));
      end
    end

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (pending != 0) $error("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/sks_pkg.sv
sv/sorted_key_set_insert_remove.sv
sim/sorted_key_set_insert_remove_checker.sv
sim/sorted_key_set_insert_remove_test.sv
